// File: sv/ptw_pkg.sv
// Package for the page table walker: geometry constants, state machine type.
// No dependencies.
package ptw_pkg;
    localparam int OFFSET_BITS  = 3;
    localparam int TABLE_LEVELS = 3;
    localparam int FRAME_COUNT  = 32;
    localparam int WORD_BITS    = 32;

    localparam int PAGE_WORDS = 1 << OFFSET_BITS;
    localparam int PAGE_BITS  = OFFSET_BITS * TABLE_LEVELS;
    localparam int PAGE_COUNT = 1 << PAGE_BITS;
    localparam int VA_BITS    = OFFSET_BITS * (TABLE_LEVELS + 1);
    localparam int FRAME_BITS = $clog2(FRAME_COUNT);
    localparam int MEM_WORDS  = FRAME_COUNT * PAGE_WORDS;
    localparam int MEM_ABITS  = FRAME_BITS + OFFSET_BITS;
    localparam int SWAP_WORDS = PAGE_COUNT * PAGE_WORDS;
    localparam int SWAP_ABITS = PAGE_BITS + OFFSET_BITS;
    localparam int LVL_BITS   = $clog2(TABLE_LEVELS + 1);

    typedef enum logic [4:0] {
        ST_CLEAR,      // zero the frame memory and swap flags after reset
        ST_IDLE,
        ST_WALK_RD,    // issue read of the table slot for this level
        ST_WALK_CHK,   // inspect slot value
        ST_SRCH_INIT,
        ST_SRCH_RD,    // issue read of a table entry during search
        ST_SRCH_CHK,
        ST_SRCH_POP,   // finish one table of the search
        ST_SRCH_UNLINK,
        ST_PICK,
        ST_EV_RD,      // copy victim page to swap and zero it
        ST_EV_WR,
        ST_EV_UNLINK,
        ST_LINK,
        ST_HELD_RD,
        ST_RS_RD,      // restore page from swap
        ST_RS_WR,
        ST_ACC_RD,
        ST_ACC_DONE,
        ST_DONE
    } state_t;
endpackage

// File: sv/page_table_walk_with_eviction.sv
// Top level of the page table walker with eviction to a swap store.
// Depends on ptw_pkg and ptw_ram.
//
//  channel   | handshake               | payload
//  ----------+-------------------------+-----------------------------------
//  request   | start in, busy out      | op, virtual_address, write_value
//  result    | done out (one cycle)    | read_value, evict_count
//
// A request is taken when start is high and busy is low. A missing table
// entry starts a depth first search of the tree, an eviction copies the
// victim page to swap and zeroes it, and a restore copies a held page back
// from swap into frame memory. The frame RAM is single port.
// After reset busy stays high while the frame memory and the swap flags
// are cleared.
// The result is shown for one cycle with done; the receiver cannot stall.
module page_table_walk_with_eviction
    import ptw_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        op,
    input  logic [VA_BITS-1:0]          virtual_address,
    input  logic signed [WORD_BITS-1:0] write_value,
    output logic                        done,
    output logic signed [WORD_BITS-1:0] read_value,
    output logic [1:0]                  evict_count
);
    localparam int CLR_N = (MEM_WORDS > PAGE_COUNT) ? MEM_WORDS : PAGE_COUNT;
    localparam int CLR_BITS = $clog2(CLR_N + 1);

    state_t state_reg, state_next;

    // Memory ports.
    logic                 fm_we;
    logic [MEM_ABITS-1:0] fm_addr;
    logic [WORD_BITS-1:0] fm_wdata, fm_rdata;
    logic                 sw_we;
    logic [SWAP_ABITS-1:0] sw_addr;
    logic [WORD_BITS-1:0] sw_wdata, sw_rdata;
    logic                 sh_we;
    logic [PAGE_BITS-1:0] sh_addr;
    logic                 sh_wdata, sh_rdata;

    ptw_ram #(.WIDTH(WORD_BITS), .DEPTH(MEM_WORDS)) u_frame (
        .clk(clk), .we(fm_we), .addr(fm_addr), .wdata(fm_wdata), .rdata(fm_rdata));
    ptw_ram #(.WIDTH(WORD_BITS), .DEPTH(SWAP_WORDS)) u_swap (
        .clk(clk), .we(sw_we), .addr(sw_addr), .wdata(sw_wdata), .rdata(sw_rdata));
    ptw_ram #(.WIDTH(1), .DEPTH(PAGE_COUNT)) u_held (
        .clk(clk), .we(sh_we), .addr(sh_addr), .wdata(sh_wdata), .rdata(sh_rdata));

    // Request registers.
    logic                 op_reg;
    logic [VA_BITS-1:0]   va_reg;
    logic [WORD_BITS-1:0] wv_reg;
    logic [PAGE_BITS-1:0] page;
    assign page = va_reg[VA_BITS-1:OFFSET_BITS];

    // Walk and search registers. Table entries are kept at full word width
    // so corrupt entries (beyond frame memory) can be recognized.
    logic [CLR_BITS-1:0]  clr_reg;
    logic [LVL_BITS-1:0]  lvl_reg;
    logic [WORD_BITS-1:0] parent_reg, child_reg;
    logic [1:0]           ev_reg;
    logic [WORD_BITS-1:0] stk_frame_reg [TABLE_LEVELS+1];
    logic [WORD_BITS-1:0] stk_link_reg  [TABLE_LEVELS+1];
    logic [OFFSET_BITS:0] stk_idx_reg   [TABLE_LEVELS+1];
    logic                 stk_any_reg   [TABLE_LEVELS+1];
    logic [PAGE_BITS-1:0] stk_page_reg  [TABLE_LEVELS+1];
    logic [LVL_BITS-1:0]  dep_reg;
    logic [WORD_BITS-1:0] empty_reg, max_reg;
    logic [PAGE_BITS:0]   vdist_reg;
    logic                 vvalid_reg;
    logic [WORD_BITS-1:0] vframe_reg, vlink_reg;
    logic [PAGE_BITS-1:0] vpage_reg;
    logic [OFFSET_BITS:0] wcnt_reg;
    logic [WORD_BITS-1:0] res_reg;

    // True when a word-wide frame number lies inside frame memory.
    function automatic logic in_mem(input logic [WORD_BITS-1:0] f);
        return f < WORD_BITS'(FRAME_COUNT);
    endfunction

    // A link is a word address inside frame memory.
    function automatic logic in_words(input logic [WORD_BITS-1:0] a);
        return a < WORD_BITS'(MEM_WORDS);
    endfunction

    function automatic logic [MEM_ABITS-1:0] maddr(input logic [WORD_BITS-1:0] f,
                                                    input logic [OFFSET_BITS-1:0] o);
        return {f[FRAME_BITS-1:0], o};
    endfunction

    function automatic logic [PAGE_BITS:0] cdist(input logic [PAGE_BITS-1:0] a,
                                                 input logic [PAGE_BITS-1:0] b);
        logic [PAGE_BITS:0] d, e;
        d = (a > b) ? {1'b0, a - b} : {1'b0, b - a};
        e = (PAGE_BITS+1)'(PAGE_COUNT) - d;
        return (e < d) ? e : d;
    endfunction

    // Index of the table slot for the current walk level.
    logic [OFFSET_BITS-1:0] walk_idx;
    always_comb
    begin
        walk_idx = '0;
        for (int l = 0; l < TABLE_LEVELS; l++)
        begin
            if (lvl_reg == LVL_BITS'(l))
            begin
                walk_idx = va_reg[OFFSET_BITS*(TABLE_LEVELS-l) +: OFFSET_BITS];
            end
        end
    end

    logic [WORD_BITS-1:0] cur_frame, cur_link;
    logic [OFFSET_BITS:0] cur_idx;
    logic                 cur_any;
    logic [PAGE_BITS-1:0] cur_page;
    assign cur_frame = stk_frame_reg[dep_reg];
    assign cur_link  = stk_link_reg[dep_reg];
    assign cur_idx   = stk_idx_reg[dep_reg];
    assign cur_any   = stk_any_reg[dep_reg];
    assign cur_page  = stk_page_reg[dep_reg];

    logic [WORD_BITS-1:0] srd;  // search read value, corrupt frames read zero
    assign srd = in_mem(cur_frame) ? fm_rdata : '0;
    logic [WORD_BITS-1:0] wrd;
    assign wrd = in_mem(parent_reg) ? fm_rdata : '0;
    // A victim frame outside frame memory swaps out zeros.
    assign sw_wdata = in_mem(vframe_reg) ? fm_rdata : '0;
    logic last_word;
    assign last_word = wcnt_reg == (OFFSET_BITS+1)'(PAGE_WORDS - 1);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:       if (clr_reg == CLR_BITS'(CLR_N - 1)) state_next = ST_IDLE;
            ST_IDLE:        if (start) state_next = ST_WALK_RD;
            ST_WALK_RD:     state_next = ST_WALK_CHK;
            ST_WALK_CHK:
            begin
                if (wrd != '0)
                    state_next = (lvl_reg == LVL_BITS'(TABLE_LEVELS - 1)) ? ST_HELD_RD
                                                                         : ST_WALK_RD;
                else
                    state_next = ST_SRCH_INIT;
            end
            ST_SRCH_INIT:   state_next = ST_SRCH_RD;
            ST_SRCH_RD:
            begin
                if (dep_reg >= LVL_BITS'(TABLE_LEVELS) ||
                    cur_idx == (OFFSET_BITS+1)'(PAGE_WORDS))
                    state_next = ST_SRCH_POP;
                else
                    state_next = ST_SRCH_CHK;
            end
            ST_SRCH_CHK:    state_next = ST_SRCH_RD;
            ST_SRCH_POP:
            begin
                if (dep_reg < LVL_BITS'(TABLE_LEVELS) && !cur_any && cur_frame != '0 &&
                    cur_frame != parent_reg && empty_reg == '0)
                    state_next = ST_SRCH_UNLINK;
                else if (dep_reg == '0)
                    state_next = ST_PICK;
                else
                    state_next = ST_SRCH_RD;
            end
            ST_SRCH_UNLINK: state_next = (dep_reg == '0) ? ST_PICK : ST_SRCH_RD;
            ST_PICK:
            begin
                if (empty_reg != '0 || max_reg < WORD_BITS'(FRAME_COUNT - 1))
                    state_next = ST_LINK;
                else if (!vvalid_reg)
                    state_next = ST_DONE;
                else
                    state_next = ST_EV_RD;
            end
            ST_EV_RD:       state_next = ST_EV_WR;
            ST_EV_WR:       state_next = last_word ? ST_EV_UNLINK : ST_EV_RD;
            ST_EV_UNLINK:   state_next = ST_LINK;
            ST_LINK:
                state_next = (lvl_reg == LVL_BITS'(TABLE_LEVELS - 1)) ? ST_HELD_RD
                                                                     : ST_WALK_RD;
            ST_HELD_RD:     state_next = ST_RS_RD;
            ST_RS_RD:       state_next = sh_rdata ? ST_RS_WR : ST_ACC_RD;
            ST_RS_WR:       state_next = last_word ? ST_ACC_RD : ST_RS_RD;
            ST_ACC_RD:      state_next = ST_ACC_DONE;
            ST_ACC_DONE:    state_next = ST_DONE;
            ST_DONE:        state_next = ST_IDLE;
            default:        state_next = ST_IDLE;
        endcase
    end

    // Memory port control.
    always_comb
    begin
        fm_we    = 1'b0;
        fm_addr  = '0;
        fm_wdata = '0;
        sw_we    = 1'b0;
        sw_addr  = {vpage_reg, wcnt_reg[OFFSET_BITS-1:0]};
        sh_we    = 1'b0;
        sh_addr  = page;
        sh_wdata = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                fm_we = clr_reg < CLR_BITS'(MEM_WORDS);
                fm_addr = clr_reg[MEM_ABITS-1:0];
                sh_we = clr_reg < CLR_BITS'(PAGE_COUNT);
                sh_addr = clr_reg[PAGE_BITS-1:0];
            end
            ST_WALK_RD:  fm_addr = maddr(parent_reg, walk_idx);
            ST_SRCH_RD:  fm_addr = maddr(cur_frame, cur_idx[OFFSET_BITS-1:0]);
            ST_SRCH_POP:
            begin
                fm_we = 1'b0;
            end
            ST_SRCH_UNLINK:
            begin
                fm_we = in_words(cur_link);
                fm_addr = cur_link[MEM_ABITS-1:0];
            end
            ST_EV_RD:    fm_addr = maddr(vframe_reg, wcnt_reg[OFFSET_BITS-1:0]);
            ST_EV_WR:
            begin
                sw_we = 1'b1;
                fm_we = in_mem(vframe_reg);
                fm_addr = maddr(vframe_reg, wcnt_reg[OFFSET_BITS-1:0]);
            end
            ST_EV_UNLINK:
            begin
                fm_we = in_words(vlink_reg);
                fm_addr = vlink_reg[MEM_ABITS-1:0];
                sh_we = 1'b1;
                sh_addr = vpage_reg;
                sh_wdata = 1'b1;
            end
            ST_LINK:
            begin
                fm_we = in_mem(parent_reg);
                fm_addr = maddr(parent_reg, walk_idx);
                fm_wdata = child_reg;
            end
            ST_RS_RD:    sw_addr = {page, wcnt_reg[OFFSET_BITS-1:0]};
            ST_RS_WR:
            begin
                sw_addr = {page, wcnt_reg[OFFSET_BITS-1:0]};
                fm_we = in_mem(parent_reg);
                fm_addr = maddr(parent_reg, wcnt_reg[OFFSET_BITS-1:0]);
                fm_wdata = sw_rdata;
                sh_we = last_word;
            end
            ST_ACC_RD:
            begin
                fm_addr = maddr(parent_reg, va_reg[OFFSET_BITS-1:0]);
                fm_we = op_reg && in_mem(parent_reg);
                fm_wdata = wv_reg;
            end
            default:     fm_we = 1'b0;
        endcase
    end

    // Outputs.
    always_comb
    begin
        busy        = state_reg != ST_IDLE;
        done        = state_reg == ST_DONE;
        read_value  = res_reg;
        evict_count = ev_reg;
    end

    // Datapath registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_CLEAR;
            clr_reg    <= '0;
            lvl_reg    <= '0;
            dep_reg    <= '0;
            wcnt_reg   <= '0;
            ev_reg     <= '0;
            vvalid_reg <= 1'b0;
            op_reg     <= 1'b0;
            va_reg     <= '0;
            wv_reg     <= '0;
            parent_reg <= '0;
            child_reg  <= '0;
            empty_reg  <= '0;
            max_reg    <= '0;
            vdist_reg  <= '0;
            vframe_reg <= '0;
            vlink_reg  <= '0;
            vpage_reg  <= '0;
            res_reg    <= '0;
            for (int k = 0; k <= TABLE_LEVELS; k++)
            begin
                stk_frame_reg[k] <= '0;
                stk_link_reg[k]  <= '0;
                stk_idx_reg[k]   <= '0;
                stk_any_reg[k]   <= 1'b0;
                stk_page_reg[k]  <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                ST_CLEAR: clr_reg <= clr_reg + 1'b1;
                ST_IDLE:
                begin
                    if (start)
                    begin
                        op_reg <= op;
                        va_reg <= virtual_address;
                        wv_reg <= write_value;
                        lvl_reg <= '0;
                        parent_reg <= '0;
                        ev_reg <= '0;
                    end
                end
                ST_WALK_CHK:
                begin
                    if (wrd != '0)
                    begin
                        parent_reg <= wrd;
                        lvl_reg <= lvl_reg + 1'b1;
                    end
                end
                ST_SRCH_INIT:
                begin
                    empty_reg <= '0;
                    max_reg <= '0;
                    vdist_reg <= '0;
                    vvalid_reg <= 1'b0;
                    dep_reg <= '0;
                    stk_frame_reg[0] <= '0;
                    stk_link_reg[0] <= '0;
                    stk_idx_reg[0] <= '0;
                    stk_any_reg[0] <= 1'b0;
                    stk_page_reg[0] <= '0;
                end
                ST_SRCH_RD:
                begin
                    if (dep_reg >= LVL_BITS'(TABLE_LEVELS) &&
                        cdist(cur_page, page) > vdist_reg)
                    begin
                        vdist_reg <= cdist(cur_page, page);
                        vvalid_reg <= 1'b1;
                        vframe_reg <= cur_frame;
                        vpage_reg <= cur_page;
                        vlink_reg <= cur_link;
                    end
                end
                ST_SRCH_CHK:
                begin
                    stk_idx_reg[dep_reg] <= cur_idx + 1'b1;
                    if (srd != '0)
                    begin
                        stk_any_reg[dep_reg] <= 1'b1;
                        if (srd > max_reg)
                            max_reg <= srd;
                        dep_reg <= dep_reg + 1'b1;
                        stk_frame_reg[dep_reg + 1'b1] <= srd;
                        stk_link_reg[dep_reg + 1'b1] <=
                            WORD_BITS'({cur_frame[FRAME_BITS-1:0],
                                        cur_idx[OFFSET_BITS-1:0]});
                        stk_page_reg[dep_reg + 1'b1] <=
                            {cur_page[PAGE_BITS-OFFSET_BITS-1:0],
                             cur_idx[OFFSET_BITS-1:0]};
                        stk_idx_reg[dep_reg + 1'b1] <= '0;
                        stk_any_reg[dep_reg + 1'b1] <= 1'b0;
                    end
                end
                ST_SRCH_POP:
                begin
                    if (dep_reg < LVL_BITS'(TABLE_LEVELS) && !cur_any && cur_frame != '0 &&
                        cur_frame != parent_reg && empty_reg == '0)
                        empty_reg <= cur_frame;
                    else if (dep_reg != '0)
                        dep_reg <= dep_reg - 1'b1;
                end
                ST_SRCH_UNLINK:
                begin
                    if (dep_reg != '0)
                        dep_reg <= dep_reg - 1'b1;
                end
                ST_PICK:
                begin
                    wcnt_reg <= '0;
                    if (empty_reg != '0)
                        child_reg <= empty_reg;
                    else if (max_reg < WORD_BITS'(FRAME_COUNT - 1))
                        child_reg <= max_reg + 1'b1;
                    else
                    begin
                        child_reg <= vframe_reg;
                        if (!vvalid_reg)
                            res_reg <= '0;
                    end
                end
                ST_EV_WR:   wcnt_reg <= last_word ? '0 : wcnt_reg + 1'b1;
                ST_EV_UNLINK:
                begin
                    if (ev_reg != 2'd3)
                        ev_reg <= ev_reg + 1'b1;
                end
                ST_LINK:
                begin
                    parent_reg <= child_reg;
                    lvl_reg <= lvl_reg + 1'b1;
                    wcnt_reg <= '0;
                end
                ST_HELD_RD: wcnt_reg <= '0;
                ST_RS_WR:   wcnt_reg <= last_word ? '0 : wcnt_reg + 1'b1;
                ST_ACC_DONE:
                    res_reg <= op_reg ? wv_reg : wrd;
                default:    clr_reg <= clr_reg;
            endcase
        end
    end

    // A restore only runs while the page is marked as held in swap.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_RS_WR |-> sh_rdata || $past(state_reg) == ST_RS_WR)
        else $error("restore without held flag");
    // The search stack never goes deeper than one past the last table level.
    assert property (@(posedge clk) disable iff (!rst_n)
        dep_reg <= LVL_BITS'(TABLE_LEVELS))
        else $error("search depth overflow");
    // Done lasts one cycle and is followed by idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done && !busy)
        else $error("done not single cycle");
    // An eviction only starts with a valid victim.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_PICK && state_next == ST_EV_RD |-> vvalid_reg)
        else $error("eviction without victim");
endmodule

// File: sv/ptw_ram.sv
// Generic single port RAM with registered read.
// No dependencies.
module ptw_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
